// ----- hdl/assert_macros.svh -----
// Assertion helpers for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/sesf_pkg.sv -----
package sesf_pkg;

  localparam int SESF_FRAC_BITS = 14;
  localparam int COORD_W = 16;
  localparam int VAL_W = 16;
  localparam int NODE_W = 3;
  localparam int IN_DEPTH = 2;
  localparam int IN_PTR_W = $clog2(IN_DEPTH);
  localparam int IN_CNT_W = $clog2(IN_DEPTH + 1);
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int SAT_W = 96;

  typedef enum logic [1:0] {
    KIND_TETRA = 2'd0,
    KIND_WEDGE = 2'd1,
    KIND_HEXA  = 2'd2,
    KIND_NONE  = 2'd3
  } elem_kind_t;

  // Bit k is set where hexahedron node k has a positive sign on that axis.
  localparam logic [7:0] HEX_POS_R = 8'b0110_0110;
  localparam logic [7:0] HEX_POS_S = 8'b1100_1100;
  localparam logic [7:0] HEX_POS_T = 8'b1111_0000;

  typedef struct packed {
    elem_kind_t         kind;
    logic [COORD_W-1:0] coord_r;
    logic [COORD_W-1:0] coord_s;
    logic [COORD_W-1:0] coord_t;
  } elem_item_t;

  typedef struct packed {
    elem_kind_t        kind;
    logic [NODE_W-1:0] node;
    logic              last;
  } node_ctl_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic [VAL_W-1:0]  shape_value;
    logic [VAL_W-1:0]  deriv_r;
    logic [VAL_W-1:0]  deriv_s;
    logic [VAL_W-1:0]  deriv_t;
    logic              last_node;
  } node_result_t;

  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(32767);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-32768);

  function automatic logic [NODE_W-1:0] last_node_of(input elem_kind_t kind);
    logic [NODE_W-1:0] idx;
    case (kind)
      KIND_TETRA: idx = NODE_W'(3);
      KIND_WEDGE: idx = NODE_W'(5);
      default:    idx = NODE_W'(7);
    endcase
    return idx;
  endfunction

  function automatic logic [VAL_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
    logic [VAL_W-1:0] res;
    if (v > SAT_HI) begin
      res = SAT_HI[VAL_W-1:0];
    end else if (v < SAT_LO) begin
      res = SAT_LO[VAL_W-1:0];
    end else begin
      res = v[VAL_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- hdl/solid_element_shape_functions.sv -----
// Shape functions of solid elements: 4-node tetrahedron, 6-node wedge and
// 8-node hexahedron, evaluated at one local point (r, s, t).
// Input channel: a beat carries opcode and coord_r/s/t; it is taken on a
// rising edge with push high and full low. Two elements can wait in the
// input queue. An opcode of none is taken and produces no results.
// Result channel: one beat per node, in node order, with last_node set on
// the final node; the head result is valid while empty is low and is taken
// on a rising edge with pop high.
// The first node of an element passes the input queue, the factor, product
// and rounding registers and the result queue before it reaches the ports.
// Throughput: one node per cycle while the result queue has room for it,
// through a four-stage arithmetic pipeline; elements follow back to back.
// When the receiver stalls, the eight-entry result queue fills, node issue
// stops, and full rises once the input queue holds two elements.
// Reset (synchronous, active high) empties both queues and drops any work
// in flight; no result appears until new input beats arrive.
`include "assert_macros.svh"

module solid_element_shape_functions import sesf_pkg::*; #(
  parameter int FRAC_BITS = SESF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         opcode,
  input  logic [COORD_W-1:0] coord_r,
  input  logic [COORD_W-1:0] coord_s,
  input  logic [COORD_W-1:0] coord_t,
  output logic               empty,
  input  logic               pop,
  output logic [NODE_W-1:0]  node_index,
  output logic [VAL_W-1:0]   shape_value,
  output logic [VAL_W-1:0]   deriv_r,
  output logic [VAL_W-1:0]   deriv_s,
  output logic [VAL_W-1:0]   deriv_t,
  output logic               last_node
);

  logic                 item_valid;
  elem_item_t           item;
  logic                 item_pop;
  logic [OUT_CNT_W-1:0] out_count;
  logic                 res_valid;
  node_result_t         res;
  node_result_t         head;

  sesf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .coord_r    (coord_r),
    .coord_s    (coord_s),
    .coord_t    (coord_t),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  sesf_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_count  (out_count),
    .res_valid  (res_valid),
    .res        (res)
  );

  sesf_out_fifo u_out (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_valid),
    .wdata (res),
    .pop   (pop),
    .empty (empty),
    .rdata (head),
    .count (out_count)
  );

  assign node_index  = head.node_index;
  assign shape_value = head.shape_value;
  assign deriv_r     = head.deriv_r;
  assign deriv_s     = head.deriv_s;
  assign deriv_t     = head.deriv_t;
  assign last_node   = head.last_node;

  // A node leaving the pipeline always finds room in the result queue.
  `ASSERT_IMPLY(a_out_room, clk, rst, res_valid && !(pop && !empty), out_count < OUT_CNT_W'(OUT_DEPTH))
  // The sequencer retires an element only while one is waiting.
  `ASSERT_IMPLY(a_pop_has_item, clk, rst, item_pop, item_valid)
  // Reset leaves both queues empty.
  `ASSERT_NEXT(a_reset_clears, clk, 1'b0, rst, empty && !full && !item_valid)

endmodule

// ----- hdl/sesf_front.sv -----
module sesf_front import sesf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         opcode,
  input  logic [COORD_W-1:0] coord_r,
  input  logic [COORD_W-1:0] coord_s,
  input  logic [COORD_W-1:0] coord_t,
  output logic               item_valid,
  output elem_item_t         item,
  input  logic               item_pop
);

  elem_item_t          slots [IN_DEPTH];
  logic [IN_PTR_W-1:0] wr_ptr;
  logic [IN_PTR_W-1:0] rd_ptr;
  logic [IN_CNT_W-1:0] count;
  logic [IN_CNT_W-1:0] count_next;
  logic                store;
  logic                take;

  assign full = (count == IN_CNT_W'(IN_DEPTH));
  // Elements of kind none are accepted and dropped here.
  assign store = push && !full && (elem_kind_t'(opcode) != KIND_NONE);
  assign item_valid = (count != '0);
  assign take = item_pop && item_valid;
  assign item = slots[rd_ptr];

  always_comb begin
    count_next = count + IN_CNT_W'(store) - IN_CNT_W'(take);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (store) begin
        wr_ptr <= (wr_ptr == IN_PTR_W'(IN_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == IN_PTR_W'(IN_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      slots[wr_ptr] <= '{kind: elem_kind_t'(opcode), coord_r: coord_r,
                         coord_s: coord_s, coord_t: coord_t};
    end
  end

endmodule

// ----- hdl/sesf_back.sv -----
module sesf_back import sesf_pkg::*; #(
  parameter int FRAC_BITS = SESF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  elem_item_t           item,
  output logic                 item_pop,
  input  logic [OUT_CNT_W-1:0] out_count,
  output logic                 res_valid,
  output node_result_t         res
);

  localparam int FW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int PW = 2 * FW;
  localparam int MW = PW - FRAC_BITS;
  localparam int MFW = MW + FW;
  localparam int CR_W = OUT_CNT_W + 2;

  localparam logic signed [FW-1:0] ONE = FW'(1) <<< FRAC_BITS;
  localparam logic signed [PW-1:0] ONE_P = PW'(ONE);
  localparam logic signed [PW-1:0] RND_F = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] RND_F1 = PW'(1) <<< FRAC_BITS;
  localparam logic signed [PW-1:0] RND_F3 = PW'(1) <<< (FRAC_BITS + 2);
  localparam logic signed [MFW-1:0] RND_M3 = MFW'(1) <<< (FRAC_BITS + 2);

  // Issue sequencer.
  logic [NODE_W-1:0] node;
  logic [NODE_W-1:0] node_next;
  logic              issue;
  logic              is_last;
  logic [CR_W-1:0]   pending;

  // Stage 1: factors.
  logic signed [FW-1:0] r_x, s_x, t_x;
  logic signed [FW-1:0] a_c, b_c, c_c;
  logic                 w_upper;
  logic [1:0]           w_j;
  logic signed [FW-1:0] a1, b1, c1;
  node_ctl_t            ctl1;
  logic                 v1;

  // Stage 2: products.
  logic signed [PW-1:0] p_ab2, p_bc2, p_ac2;
  logic signed [FW-1:0] a2, b2, c2;
  node_ctl_t            ctl2;
  logic                 v2;

  // Stage 3: rounding, second hexa product, signs.
  logic signed [PW-1:0] m_full;
  logic signed [MW-1:0] m3;
  logic signed [PW-1:0] hr_ab, hr_bc, hr_ac, w_n;
  logic signed [FW-1:0] w_h, w_dt;
  logic                 s3_upper;
  logic [1:0]           s3_j;
  logic signed [PW-1:0] n_c, dr_c, ds_c, dt_c;
  logic signed [MFW-1:0] pm3;
  logic signed [PW-1:0] n3, dr3, ds3, dt3;
  node_ctl_t            ctl3;
  logic                 v3;

  // Stage 4: final rounding and saturation.
  logic signed [MFW-1:0] hex_n;

  assign pending = CR_W'(out_count) + CR_W'(v1) + CR_W'(v2) + CR_W'(v3);
  assign issue = item_valid && (pending < CR_W'(OUT_DEPTH));
  assign is_last = (node == last_node_of(item.kind));
  assign item_pop = issue && is_last;

  always_comb begin
    node_next = node;
    if (issue) begin
      node_next = is_last ? '0 : node + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node <= '0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
    end else begin
      node <= node_next;
      v1   <= issue;
      v2   <= v1;
      v3   <= v2;
    end
  end

  assign r_x = FW'($signed(item.coord_r));
  assign s_x = FW'($signed(item.coord_s));
  assign t_x = FW'($signed(item.coord_t));
  assign w_upper = (node >= NODE_W'(3));
  assign w_j = w_upper ? 2'(node - NODE_W'(3)) : node[1:0];

  always_comb begin
    a_c = '0;
    b_c = '0;
    c_c = '0;
    case (item.kind)
      KIND_HEXA: begin
        a_c = HEX_POS_R[node] ? ONE + r_x : ONE - r_x;
        b_c = HEX_POS_S[node] ? ONE + s_x : ONE - s_x;
        c_c = HEX_POS_T[node] ? ONE + t_x : ONE - t_x;
      end
      KIND_WEDGE: begin
        case (w_j)
          2'd0:    a_c = ONE - r_x - s_x;
          2'd1:    a_c = r_x;
          default: a_c = s_x;
        endcase
        b_c = w_upper ? ONE + t_x : ONE - t_x;
      end
      default: begin
        case (node[1:0])
          2'd0:    a_c = ONE - r_x - s_x - t_x;
          2'd1:    a_c = r_x;
          2'd2:    a_c = s_x;
          default: a_c = t_x;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a1   <= a_c;
    b1   <= b_c;
    c1   <= c_c;
    ctl1 <= '{kind: item.kind, node: node, last: is_last};
  end

  always_ff @(posedge clk) begin
    p_ab2 <= PW'(a1) * PW'(b1);
    p_bc2 <= PW'(b1) * PW'(c1);
    p_ac2 <= PW'(a1) * PW'(c1);
    a2    <= a1;
    b2    <= b1;
    c2    <= c1;
    ctl2  <= ctl1;
  end

  assign m_full = (p_ab2 + RND_F) >>> FRAC_BITS;
  assign m3 = m_full[MW-1:0];
  assign hr_ab = (p_ab2 + RND_F3) >>> (FRAC_BITS + 3);
  assign hr_bc = (p_bc2 + RND_F3) >>> (FRAC_BITS + 3);
  assign hr_ac = (p_ac2 + RND_F3) >>> (FRAC_BITS + 3);
  assign w_n = (p_ab2 + RND_F1) >>> (FRAC_BITS + 1);
  assign w_h = (b2 + FW'(1)) >>> 1;
  assign w_dt = (a2 + FW'(1)) >>> 1;
  assign s3_upper = (ctl2.node >= NODE_W'(3));
  assign s3_j = s3_upper ? 2'(ctl2.node - NODE_W'(3)) : ctl2.node[1:0];

  // Negative terms are the negation of the already rounded magnitude.
  always_comb begin
    n_c  = '0;
    dr_c = '0;
    ds_c = '0;
    dt_c = '0;
    case (ctl2.kind)
      KIND_HEXA: begin
        dr_c = HEX_POS_R[ctl2.node] ? hr_bc : -hr_bc;
        ds_c = HEX_POS_S[ctl2.node] ? hr_ac : -hr_ac;
        dt_c = HEX_POS_T[ctl2.node] ? hr_ab : -hr_ab;
      end
      KIND_WEDGE: begin
        n_c = w_n;
        case (s3_j)
          2'd0: begin
            dr_c = -PW'(w_h);
            ds_c = -PW'(w_h);
          end
          2'd1:    dr_c = PW'(w_h);
          default: ds_c = PW'(w_h);
        endcase
        dt_c = s3_upper ? PW'(w_dt) : -PW'(w_dt);
      end
      default: begin
        n_c = PW'(a2);
        case (ctl2.node[1:0])
          2'd0: begin
            dr_c = -ONE_P;
            ds_c = -ONE_P;
            dt_c = -ONE_P;
          end
          2'd1:    dr_c = ONE_P;
          2'd2:    ds_c = ONE_P;
          default: dt_c = ONE_P;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pm3  <= MFW'(m3) * MFW'(c2);
    n3   <= n_c;
    dr3  <= dr_c;
    ds3  <= ds_c;
    dt3  <= dt_c;
    ctl3 <= ctl2;
  end

  assign hex_n = (pm3 + RND_M3) >>> (FRAC_BITS + 3);
  assign res_valid = v3;

  always_comb begin
    res.node_index  = ctl3.node;
    res.shape_value = (ctl3.kind == KIND_HEXA) ? sat16(SAT_W'(hex_n)) : sat16(SAT_W'(n3));
    res.deriv_r     = sat16(SAT_W'(dr3));
    res.deriv_s     = sat16(SAT_W'(ds3));
    res.deriv_t     = sat16(SAT_W'(dt3));
    res.last_node   = ctl3.last;
  end

endmodule

// ----- hdl/sesf_out_fifo.sv -----
module sesf_out_fifo import sesf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  node_result_t         wdata,
  input  logic                 pop,
  output logic                 empty,
  output node_result_t         rdata,
  output logic [OUT_CNT_W-1:0] count
);

  node_result_t         slots [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_CNT_W-1:0] count_next;
  logic                 take;

  assign empty = (count == '0);
  assign take = pop && !empty;
  assign rdata = slots[rd_ptr];

  always_comb begin
    count_next = count + OUT_CNT_W'(wr) - OUT_CNT_W'(take);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr) begin
        wr_ptr <= (wr_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule
